>>> rtl/mts_pkg.sv
// package for the min tracking stack
// beat payload structs, command and status structs, codes and controller states
package mts_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned LevelWidth = 11;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_RESP
  } ctrl_state_e;

  typedef struct packed {
    req_e                        req_type;
    logic signed [DataWidth-1:0] push_value;
  } mts_req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] top_value;
    logic signed [DataWidth-1:0] min_value;
    logic [LevelWidth-1:0]       fill_level;
    logic                        is_empty;
    status_e                     status;
  } mts_rsp_t;

  typedef struct packed {
    logic    push;
    logic    pop;
    logic    load_top;
    logic    out_load;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic deep;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/mts_ctrl.sv
// controller state machine for the min tracking stack
// depends on mts_pkg; drives dp_cmd_t to mts_datapath
module mts_ctrl import mts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_e       req_type_i,
  input  dp_status_t dp_status_i,
  output dp_cmd_t    dp_cmd_o
);

  ctrl_state_e state_q, state_d;
  status_e     status_q, status_d;
  logic        accept;

  assign accept = (state_q == S_IDLE) && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= STATUS_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_POP && !dp_status_i.empty && dp_status_i.deep) begin
            state_d = S_LOAD;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_LOAD: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (dp_status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    dp_cmd_o          = '0;
    dp_cmd_o.status   = status_q;
    status_d          = status_q;
    in_stall_o        = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_PUSH) begin
            if (dp_status_i.full) begin
              status_d = STATUS_OVERFLOW;
            end else begin
              status_d      = STATUS_OK;
              dp_cmd_o.push = 1'b1;
            end
          end else begin
            if (dp_status_i.empty) begin
              status_d = STATUS_UNDERFLOW;
            end else begin
              status_d     = STATUS_OK;
              dp_cmd_o.pop = 1'b1;
            end
          end
        end
      end
      S_LOAD: begin
        dp_cmd_o.load_top = 1'b1;
      end
      S_RESP: begin
        dp_cmd_o.out_load = dp_status_i.out_free;
      end
      default: begin
        dp_cmd_o = '0;
      end
    endcase
  end

endmodule

>>> rtl/mts_datapath.sv
// datapath for the min tracking stack: top registers, entry memory, output register
// depends on mts_pkg; commanded by mts_ctrl
module mts_datapath import mts_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic signed [DataWidth-1:0] push_value_i,
  input  dp_cmd_t    dp_cmd_i,
  output dp_status_t dp_status_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output mts_rsp_t   out_data_o
);

  localparam int unsigned AddrWidth  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CountWidth = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EntryWidth = 2 * DataWidth;

  logic [CountWidth-1:0]       count_q, count_d;
  logic signed [DataWidth-1:0] top_val_q, top_min_q;
  logic [EntryWidth-1:0]       rd_q;
  logic [EntryWidth-1:0]       mem [STACK_DEPTH];
  logic [CountWidth-1:0]       below_idx, next_idx;
  logic [AddrWidth-1:0]        wr_addr, rd_addr;
  logic signed [DataWidth-1:0] new_min;
  logic                        out_valid_q;
  mts_rsp_t                    out_q;
  mts_rsp_t                    rsp;
  logic [LevelWidth+CountWidth-1:0] fill_wide;

  assign below_idx = count_q - CountWidth'(1);
  assign next_idx  = count_q - CountWidth'(2);
  assign wr_addr   = below_idx[AddrWidth-1:0];
  assign rd_addr   = next_idx[AddrWidth-1:0];

  assign new_min = ((count_q != '0) && (top_min_q < push_value_i)) ? top_min_q : push_value_i;

  always_comb begin
    count_d = count_q;
    if (dp_cmd_i.push) begin
      count_d = count_q + CountWidth'(1);
    end else if (dp_cmd_i.pop) begin
      count_d = below_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (dp_cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // entry memory holds the levels below the top
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.push && (count_q != '0)) begin
      mem[wr_addr] <= {top_val_q, top_min_q};
    end
    if (dp_cmd_i.pop) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.push) begin
      top_val_q <= push_value_i;
      top_min_q <= new_min;
    end else if (dp_cmd_i.load_top) begin
      top_val_q <= rd_q[EntryWidth-1:DataWidth];
      top_min_q <= rd_q[DataWidth-1:0];
    end
    if (dp_cmd_i.out_load) begin
      out_q <= rsp;
    end
  end

  assign fill_wide = {{LevelWidth{1'b0}}, count_q};

  always_comb begin
    rsp.is_empty   = (count_q == '0);
    rsp.top_value  = rsp.is_empty ? '0 : top_val_q;
    rsp.min_value  = rsp.is_empty ? '0 : top_min_q;
    rsp.fill_level = fill_wide[LevelWidth-1:0];
    rsp.status     = dp_cmd_i.status;
  end

  assign dp_status_o.empty    = (count_q == '0);
  assign dp_status_o.full     = (count_q >= CountWidth'(STACK_DEPTH));
  assign dp_status_o.deep     = (count_q >= CountWidth'(2));
  assign dp_status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/min_tracking_stack.sv
// min tracking stack: lifo of signed 32-bit values reporting the smallest value held
// a push or an ignored request goes from idle to the response state, which loads
// the output register; a pop exposing a stored entry first takes the new top from
// the registered memory read in a load state; requests wait for the output register
// reset: asynchronous, empties the stack; the entry memory is not cleared
module min_tracking_stack import mts_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mts_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mts_rsp_t out_data_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (in_data_i.req_type),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_value_i (in_data_i.push_value),
    .dp_cmd_i     (dp_cmd),
    .dp_status_o  (dp_status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
